/* rtl/core/erm_pkg.sv */
package erm_pkg;

	localparam int TS_W       = 32;
	localparam int SPEED_W    = 16;
	localparam int THR_W      = 12;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int HALF_W     = TS_W - 1;
	localparam int PROD_W     = HALF_W + SPEED_W;
	localparam int FRAC_SHIFT = 12;
	localparam int Q4_SHIFT   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

	localparam logic [SPEED_W-1:0] SPEED_RESET     = 16'd22938;
	localparam logic [THR_W-1:0]   THRESHOLD_RESET = 12'd180;

	typedef struct packed {
		logic load_rise;
		logic load_diff;
		logic mul;
		logic shift_in;
		logic sort;
		logic sort_odd;
		logic sum_clear;
		logic sum_step;
		logic sum_add;
		logic div_mul;
		logic load_out;
	} erm_cmd_t;

endpackage

/* rtl/core/erm_if.sv */
interface erm_echo_if
	import erm_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            echo_level;
	logic [TS_W-1:0] timestamp_us;

	modport source (output valid, output echo_level, output timestamp_us, input ready);
	modport sink   (input valid, input echo_level, input timestamp_us, output ready);
endinterface

interface erm_result_if
	import erm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] trimmed_mean_q4;
	logic                obstacle_near;

	modport source (output valid, output trimmed_mean_q4, output obstacle_near, input ready);
	modport sink   (input valid, input trimmed_mean_q4, input obstacle_near, output ready);
endinterface

/* rtl/core/erm_dpath.sv */
module erm_dpath
	import erm_pkg::*;
#(
	parameter int WINDOW = 20,
	parameter int TRIM   = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  erm_cmd_t             cmd,
	input  logic [TS_W-1:0]      timestamp_us,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [SAMPLE_W-1:0]  trimmed_mean_q4,
	output logic                 obstacle_near
);
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
	localparam int NMID     = (2 * TRIM < WINDOW) ? (WINDOW - 2 * TRIM) : 1;
	localparam int RECIP_SH = SUM_W + $clog2(NMID);
	localparam int RECIP_W  = SUM_W + 1;
	localparam int QPROD_W  = SUM_W + RECIP_W;
	// ceil(2^RECIP_SH / NMID): exact floor division for every sum below 2^SUM_W
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((longint'(1) << RECIP_SH) + longint'(NMID) - 1) / longint'(NMID));

	logic [SPEED_W-1:0]  speed_q;
	logic [THR_W-1:0]    thresh_q;
	logic [TS_W-1:0]     rise_q;
	logic [TS_W-1:0]     diff;
	logic [HALF_W-1:0]   half_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SAMPLE_W-1:0] sample;
	logic [SAMPLE_W-1:0] win_q [WINDOW];
	logic [SAMPLE_W-1:0] sorted [WINDOW];
	logic [SUM_W-1:0]    sum_q;
	logic [QPROD_W-1:0]  qprod;
	logic [SAMPLE_W-1:0] quot_q;
	logic [SAMPLE_W-1:0] thresh_q4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= SPEED_RESET;
			thresh_q <= THRESHOLD_RESET;
			rise_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED:     speed_q  <= cfg_data[SPEED_W-1:0];
					REG_THRESHOLD: thresh_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_rise) begin
				rise_q <= timestamp_us;
			end
		end
	end

	assign diff = timestamp_us - rise_q;

	// saturate (half span * speed) >> 12 to 16 bits
	assign sample = (|prod_q[PROD_W-1:FRAC_SHIFT+SAMPLE_W]) ? {SAMPLE_W{1'b1}}
		: prod_q[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];

	// odd-even transposition pass
	always_comb begin
		sorted = win_q;
		for (int i = 0; i < WINDOW - 1; i++) begin
			if ((i % 2 == 1) == cmd.sort_odd && win_q[i] > win_q[i+1]) begin
				sorted[i]   = win_q[i+1];
				sorted[i+1] = win_q[i];
			end
		end
	end

	assign qprod     = QPROD_W'(sum_q) * QPROD_W'(RECIP);
	assign thresh_q4 = {thresh_q, {Q4_SHIFT{1'b0}}};

	always_ff @(posedge clk) begin
		if (cmd.load_diff) begin
			half_q <= diff[TS_W-1:1];
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(half_q) * PROD_W'(speed_q);
		end
		if (cmd.shift_in || cmd.sum_step) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW-1] <= cmd.shift_in ? sample : win_q[0];
		end else if (cmd.sort) begin
			win_q <= sorted;
		end
		if (cmd.sum_clear) begin
			sum_q <= '0;
		end else if (cmd.sum_step && cmd.sum_add) begin
			sum_q <= sum_q + SUM_W'(win_q[0]);
		end
		if (cmd.div_mul) begin
			quot_q <= qprod[RECIP_SH+SAMPLE_W-1:RECIP_SH];
		end
		if (cmd.load_out) begin
			trimmed_mean_q4 <= quot_q;
			obstacle_near   <= quot_q < thresh_q4;
		end
	end
endmodule

/* rtl/core/erm_ctrl.sv */
module erm_ctrl
	import erm_pkg::*;
#(
	parameter int WINDOW = 20,
	parameter int TRIM   = 5
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_level,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output erm_cmd_t cmd
);
	localparam int FILL_W   = $clog2(WINDOW);
	localparam int STEP_W   = $clog2(WINDOW);
	localparam int LO       = TRIM;
	localparam int HI       = WINDOW - TRIM;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SAT  = 3'd2;
	localparam logic [2:0] S_SORT = 3'd3;
	localparam logic [2:0] S_SUM  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [FILL_W-1:0] fill_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              last_fill;
	logic              last_win;
	logic              emit;

	assign last_fill = fill_q == FILL_W'(WINDOW - 1);
	assign last_win  = step_q == STEP_W'(WINDOW - 1);
	assign emit      = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		int step_i;
		step_i   = int'(step_q);
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_level) begin
						cmd.load_rise = 1'b1;
					end else begin
						cmd.load_diff = 1'b1;
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SAT;
			end
			S_SAT: begin
				cmd.shift_in = 1'b1;
				if (last_fill) begin
					cmd.sum_clear = 1'b1;
					state_d = S_SORT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SORT: begin
				cmd.sort     = 1'b1;
				cmd.sort_odd = step_q[0];
				if (last_win) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				cmd.sum_add  = (step_i >= LO) && (step_i < HI);
				if (last_win) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_mul = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (emit) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SAT) begin
				fill_q <= last_fill ? '0 : fill_q + 1'b1;
			end
			if (state_d != state_q) begin
				step_q <= '0;
			end else if (state_q == S_SORT || state_q == S_SUM) begin
				step_q <= step_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

/* rtl/core/echo_range_trimmed_mean.sv */
// Ultrasonic echo ranging with a trimmed-mean filter. Each transfer on echo is one
// pin edge with its microsecond timestamp. A falling edge turns the wrapped span
// into a saturated 16-bit distance sample (mm, 4 fraction bits) through one 31x16
// multiplier; the edge that fills the window of WINDOW samples then holds echo off
// for WINDOW odd-even sort passes, WINDOW summing steps over the shift line, one
// reciprocal multiplication for the division by the kept count and, if the last
// result is still waiting, until it is taken. The result sits in an output register,
// so further edges are taken while it waits.
module echo_range_trimmed_mean
	import erm_pkg::*;
#(
	parameter int WINDOW = 20,
	parameter int TRIM   = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	erm_echo_if.sink             echo,
	erm_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	erm_cmd_t cmd;

	erm_ctrl #(
		.WINDOW (WINDOW),
		.TRIM   (TRIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (echo.valid),
		.in_level  (echo.echo_level),
		.in_ready  (echo.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	erm_dpath #(
		.WINDOW (WINDOW),
		.TRIM   (TRIM)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.timestamp_us    (echo.timestamp_us),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.trimmed_mean_q4 (result.trimmed_mean_q4),
		.obstacle_near   (result.obstacle_near)
	);
endmodule

/* rtl/core/erm_checker.sv */
module erm_checker
	import erm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                in_level,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] out_mean,
	input logic                out_near
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_mean) && $stable(out_near))
		else $error("result payload changed while stalled");

	a_fall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_level |=> !in_ready)
		else $error("falling edge did not start sample work");

	a_rise_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_level |=> in_ready)
		else $error("rising edge stalled the input");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without window processing");
endmodule

bind echo_range_trimmed_mean erm_checker u_erm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (echo.valid),
	.in_ready  (echo.ready),
	.in_level  (echo.echo_level),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_mean  (result.trimmed_mean_q4),
	.out_near  (result.obstacle_near)
);
